// ----- rtl/mrt_pkg.sv -----
// Shared types, codes and helpers for the matrix reduce/transpose engine.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mrt_pkg;

  localparam int ELEM_W      = 32;
  localparam int VALUE_W     = 38;
  localparam int DIM_W       = 4;
  localparam int MODE_W      = 3;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int DEF_MAX_DIM = 8;
  localparam int QUEUE_DEPTH = 2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [1:0] REG_MODE         = 2'd2;

  localparam logic [MODE_W-1:0] MODE_PASS      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TOTAL     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROW_SUM   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COL_SUM   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRANSPOSE = 3'd4;

  localparam logic [DIM_W-1:0]  RESET_ROWS = 4'd4;
  localparam logic [DIM_W-1:0]  RESET_COLS = 4'd4;

  typedef struct packed {
    logic [DIM_W-1:0]  row_count;
    logic [DIM_W-1:0]  column_count;
    logic [MODE_W-1:0] mode;
  } cfg_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     load_done;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      row_end;
    logic                      last;
  } res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                 input logic [DIM_W-1:0] max_d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = 4'd1;
    else if (d > max_d) r = max_d;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mrt_elem_if.sv -----
// Element channel: valid/ready handshake carrying one signed matrix element.
// Depends on mrt_pkg for the element width.
`timescale 1ns / 1ps
`default_nettype none

interface mrt_elem_if;
  import mrt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

`default_nettype wire

// ----- rtl/mrt_result_if.sv -----
// Result channel: valid/ready handshake carrying value, row_end and last.
// Depends on mrt_pkg for the value width.
`timescale 1ns / 1ps
`default_nettype none

interface mrt_result_if;
  import mrt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      row_end;
  logic                      last;

  modport source (output valid, output value, output row_end, output last, input ready);
  modport sink   (input valid, input value, input row_end, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/mrt_queue.sv -----
// Small valid/ready FIFO used between front and back and on the result side.
// Depends on mrt_pkg for the default depth.
`timescale 1ns / 1ps
`default_nettype none

module mrt_queue #(
  parameter type ENTRY_T = logic,
  parameter int  DEPTH   = mrt_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push_valid,
  output logic                              push_ready,
  input  wire ENTRY_T                       push_data,
  output logic                              pop_valid,
  input  wire logic                         pop_ready,
  output ENTRY_T                            pop_data,
  output logic [$clog2(DEPTH+1)-1:0]        count
);
  import mrt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  ENTRY_T          slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count < CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- rtl/mrt_front.sv -----
// Front end: accepts elements, tracks the load index and tags the element
// that completes the matrix. Depends on mrt_pkg and mrt_elem_if.
`timescale 1ns / 1ps
`default_nettype none

module mrt_front #(
  parameter int MAX_DIM = mrt_pkg::DEF_MAX_DIM
) (
  input  wire logic         clk,
  input  wire logic         rst,
  mrt_elem_if.sink          elements,
  input  wire mrt_pkg::cfg_t cfg,
  output logic              cmd_valid,
  input  wire logic         cmd_ready,
  output mrt_pkg::cmd_t     cmd
);
  import mrt_pkg::*;

  localparam int IW = $clog2(MAX_DIM*MAX_DIM + 1);

  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] cols;
  logic [7:0]       product;
  logic [IW-1:0]    total;
  logic [IW-1:0]    load_index;
  logic [IW-1:0]    index_inc;
  logic             done;
  logic             accept;

  assign rows      = clamp_dim(cfg.row_count, DIM_W'(MAX_DIM));
  assign cols      = clamp_dim(cfg.column_count, DIM_W'(MAX_DIM));
  assign product   = 8'(rows) * 8'(cols);
  assign total     = product[IW-1:0];
  assign index_inc = load_index + 1'b1;
  // a shrink of the dimensions mid-load ends the load at the next element
  assign done      = (index_inc >= total);

  assign elements.ready = cmd_ready;
  assign cmd_valid      = elements.valid;
  assign cmd.element    = elements.element;
  assign cmd.load_done  = done;
  assign accept         = elements.valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
    end else if (accept) begin
      load_index <= done ? '0 : index_inc;
    end
  end

  a_index_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> load_index == '0)
    else $error("load index did not restart after the final element");

endmodule

`default_nettype wire

// ----- rtl/mrt_back.sv -----
// Back end: element store, walk sequencer, accumulator and result queue.
// Depends on mrt_pkg, mrt_result_if and mrt_queue.
`timescale 1ns / 1ps
`default_nettype none

module mrt_back #(
  parameter int MAX_DIM = mrt_pkg::DEF_MAX_DIM
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mrt_pkg::cfg_t cfg,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire mrt_pkg::cmd_t cmd,
  mrt_result_if.source       results
);
  import mrt_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {ST_LOAD, ST_WALK} state_t;

  state_t           state;
  logic [AW-1:0]    wr_ptr;
  logic [CW-1:0]    outer;
  logic [CW-1:0]    inner;

  logic [ELEM_W-1:0] store [DEPTH];

  logic [DIM_W-1:0] rows;
  logic [DIM_W-1:0] cols;
  logic             col_major;
  logic             mode_ok;
  logic [DIM_W-1:0] outer_n;
  logic [DIM_W-1:0] inner_n;
  logic             inner_end;
  logic             outer_end;
  logic [CW-1:0]    row_idx;
  logic [CW-1:0]    col_idx;
  logic [7:0]       addr_full;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic             can_issue;
  logic             issue;
  logic             f_first;
  logic             f_emit;
  logic             f_row_end;
  logic             f_last;

  // read stage
  logic                      rd_valid;
  logic [ELEM_W-1:0]         rd_data;
  logic                      rd_first;
  logic                      rd_emit;
  logic                      rd_row_end;
  logic                      rd_last;
  logic signed [VALUE_W-1:0] acc;
  logic signed [VALUE_W-1:0] acc_next;

  // result queue
  logic           oq_push;
  logic           oq_ready;
  res_t           oq_in;
  res_t           oq_out;
  logic [QCW-1:0] oq_count;
  logic [QCW:0]   pending;
  logic           oq_pop;

  assign rows      = clamp_dim(cfg.row_count, DIM_W'(MAX_DIM));
  assign cols      = clamp_dim(cfg.column_count, DIM_W'(MAX_DIM));
  assign col_major = (cfg.mode == MODE_COL_SUM) || (cfg.mode == MODE_TRANSPOSE);
  assign mode_ok   = (cfg.mode <= MODE_TRANSPOSE);
  assign outer_n   = col_major ? cols : rows;
  assign inner_n   = col_major ? rows : cols;
  assign inner_end = (DIM_W'(inner) == inner_n - 4'd1);
  assign outer_end = (DIM_W'(outer) == outer_n - 4'd1);
  assign row_idx   = col_major ? inner : outer;
  assign col_idx   = col_major ? outer : inner;
  assign addr_full = 8'(row_idx) * 8'(cols) + 8'(col_idx);
  assign rd_addr   = addr_full[AW-1:0];

  assign cmd_ready = (state == ST_LOAD);
  assign wr_en     = cmd_ready && cmd_valid;

  // only issue a read once its result is sure of a queue slot
  assign oq_pop    = results.valid && results.ready;
  assign pending   = (QCW+1)'(oq_count) + (QCW+1)'(rd_valid && rd_emit)
                   - (QCW+1)'(oq_pop);
  assign can_issue = (pending < (QCW+1)'(QUEUE_DEPTH));
  assign issue     = (state == ST_WALK) && can_issue;

  always_comb begin
    f_first   = 1'b1;
    f_emit    = 1'b1;
    f_row_end = inner_end;
    f_last    = inner_end && outer_end;
    case (cfg.mode)
      MODE_PASS, MODE_TRANSPOSE: begin
        f_first   = 1'b1;
        f_emit    = 1'b1;
        f_row_end = inner_end;
      end
      MODE_TOTAL: begin
        f_first   = (outer == '0) && (inner == '0);
        f_emit    = inner_end && outer_end;
        f_row_end = 1'b1;
      end
      MODE_ROW_SUM, MODE_COL_SUM: begin
        f_first   = (inner == '0);
        f_emit    = inner_end;
        f_row_end = 1'b1;
      end
      default: begin
        f_emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      wr_ptr <= '0;
      outer  <= '0;
      inner  <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (cmd_valid) begin
            if (cmd.load_done) begin
              wr_ptr <= '0;
              outer  <= '0;
              inner  <= '0;
              if (mode_ok) state <= ST_WALK;
            end else begin
              wr_ptr <= wr_ptr + 1'b1;
            end
          end
        end
        ST_WALK: begin
          if (issue) begin
            if (inner_end) begin
              inner <= '0;
              if (outer_end) state <= ST_LOAD;
              else outer <= outer + 1'b1;
            end else begin
              inner <= inner + 1'b1;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_ptr] <= cmd.element;
    if (issue) rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_first   <= f_first;
      rd_emit    <= f_emit;
      rd_row_end <= f_row_end;
      rd_last    <= f_last;
    end
    if (rd_valid) acc <= acc_next;
  end

  assign acc_next = (rd_first ? '0 : acc) + VALUE_W'($signed(rd_data));

  assign oq_push       = rd_valid && rd_emit;
  assign oq_in.value   = acc_next;
  assign oq_in.row_end = rd_row_end;
  assign oq_in.last    = rd_last;

  mrt_queue #(
    .ENTRY_T (res_t),
    .DEPTH   (QUEUE_DEPTH)
  ) u_result_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (oq_push),
    .push_ready (oq_ready),
    .push_data  (oq_in),
    .pop_valid  (results.valid),
    .pop_ready  (results.ready),
    .pop_data   (oq_out),
    .count      (oq_count)
  );

  assign results.value   = oq_out.value;
  assign results.row_end = oq_out.row_end;
  assign results.last    = oq_out.last;

  a_no_result_drop: assert property (@(posedge clk) disable iff (rst)
    oq_push |-> oq_ready)
    else $error("result produced with no queue slot");

  a_walk_ptr_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> wr_ptr == '0)
    else $error("store pointer not rewound during walk");

endmodule

`default_nettype wire

// ----- rtl/matrix_reduce_transpose_engine.sv -----
// Top level: configuration registers, front end, command queue and back end.
// Depends on mrt_pkg, mrt_elem_if, mrt_result_if, mrt_queue, mrt_front, mrt_back.
//
//   channel    kind       payload
//   elements   sink       element (32 b signed)
//   results    source     value (38 b signed), row_end, last
//   apb        cfg write  row_count @0x0, column_count @0x4, mode @0x8
//
// Elements load at one per cycle into the element store while the back end
// is loading and the command queue has room. After the final element the
// walker reads the store once per cycle unless the result side holds it;
// loading and walking take turns on the store.
// Reset clears control state and sets the registers to their defaults; the store is not cleared.
// A stalled result side holds the walk; the front keeps taking elements
// until the two-entry command queue fills.
`timescale 1ns / 1ps
`default_nettype none

module matrix_reduce_transpose_engine #(
  parameter int MAX_DIM = mrt_pkg::DEF_MAX_DIM
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  mrt_elem_if.sink                             elements,
  mrt_result_if.source                         results,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mrt_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [mrt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mrt_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import mrt_pkg::*;

  cfg_t       cfg;
  logic [1:0] reg_index;
  logic       cmd_in_valid;
  logic       cmd_in_ready;
  cmd_t       cmd_in;
  logic       cmd_out_valid;
  logic       cmd_out_ready;
  cmd_t       cmd_out;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_count    <= RESET_ROWS;
      cfg.column_count <= RESET_COLS;
      cfg.mode         <= MODE_PASS;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        REG_ROW_COUNT:    cfg.row_count    <= pwdata[DIM_W-1:0];
        REG_COLUMN_COUNT: cfg.column_count <= pwdata[DIM_W-1:0];
        REG_MODE:         cfg.mode         <= pwdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_ROW_COUNT:    prdata = APB_DATA_W'(cfg.row_count);
      REG_COLUMN_COUNT: prdata = APB_DATA_W'(cfg.column_count);
      REG_MODE:         prdata = APB_DATA_W'(cfg.mode);
      default:          prdata = '0;
    endcase
  end

  mrt_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .elements  (elements),
    .cfg       (cfg),
    .cmd_valid (cmd_in_valid),
    .cmd_ready (cmd_in_ready),
    .cmd       (cmd_in)
  );

  mrt_queue #(
    .ENTRY_T (cmd_t),
    .DEPTH   (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_in_valid),
    .push_ready (cmd_in_ready),
    .push_data  (cmd_in),
    .pop_valid  (cmd_out_valid),
    .pop_ready  (cmd_out_ready),
    .pop_data   (cmd_out),
    .count      ()
  );

  mrt_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_out_valid),
    .cmd_ready (cmd_out_ready),
    .cmd       (cmd_out),
    .results   (results)
  );

endmodule

`default_nettype wire
